[src/ctp_pkg.sv]
package ctp_pkg;

  // Field widths
  localparam int CAP_W   = 11;
  localparam int PCAP_W  = 12;
  localparam int SOC_W   = 7;
  localparam int MIN_W   = 16;

  // Curve and datapath widths
  localparam int SEC_W   = 3;
  localparam int LEN_W   = 5;
  localparam int PWR_W   = 9;
  localparam int SP_W    = 14;
  localparam int PSUM_W  = 15;
  localparam int DL_W    = 11;
  localparam int DEN_W   = 21;
  localparam int NUM_W   = 38;
  localparam int QUO_W   = 26;
  localparam int TOT_W   = 28;
  localparam int CNT_W   = 6;
  localparam int FRAC_W  = 16;

  localparam logic [CNT_W-1:0]  DIV_STEPS   = CNT_W'(NUM_W);
  localparam logic [SOC_W-1:0]  SOC_MAX     = 7'd100;
  localparam logic [SEC_W-1:0]  LAST_SEC    = 3'd5;
  localparam logic [MIN_W-1:0]  MIN_SAT     = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } ctp_state_t;

  // Request into the bit-serial divider
  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   dividend;
    logic [DEN_W-1:0]   divisor;
  } div_req_t;

  // State of charge at each curve point
  function automatic logic [SOC_W-1:0] curve_soc(input logic [SEC_W-1:0] i);
    logic [SOC_W-1:0] v;
    case (i)
      3'd0:    v = 7'd0;
      3'd1:    v = 7'd30;
      3'd2:    v = 7'd55;
      3'd3:    v = 7'd76;
      3'd4:    v = 7'd81;
      3'd5:    v = 7'd91;
      default: v = 7'd100;
    endcase
    return v;
  endfunction

  // Charge power at each curve point, 0.1 kW
  function automatic logic [PWR_W-1:0] curve_pwr(input logic [SEC_W-1:0] i);
    logic [PWR_W-1:0] v;
    case (i)
      3'd0:    v = 9'd300;
      3'd1:    v = 9'd325;
      3'd2:    v = 9'd265;
      3'd3:    v = 9'd185;
      3'd4:    v = 9'd110;
      3'd5:    v = 9'd65;
      default: v = 9'd30;
    endcase
    return v;
  endfunction

  // Section holding soc: soc in (point[i], point[i+1]], soc 0 in section 0
  function automatic logic [SEC_W-1:0] section_of(input logic [SOC_W-1:0] soc);
    logic [SEC_W-1:0] s;
    logic             found;
    s     = LAST_SEC;
    found = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (!found && soc <= curve_soc(SEC_W'(i + 1))) begin
        s     = SEC_W'(i);
        found = 1'b1;
      end
    end
    return s;
  endfunction

  // Section length in percent
  function automatic logic [LEN_W-1:0] sec_len(input logic [SEC_W-1:0] s);
    return LEN_W'(curve_soc(s + 3'd1) - curve_soc(s));
  endfunction

  // Power at soc inside section s, scaled by the section length, floored at zero, capped
  function automatic logic [SP_W-1:0] scaled_power(input logic [SEC_W-1:0]  s,
                                                   input logic [SOC_W-1:0]  soc,
                                                   input logic [PCAP_W-1:0] cap);
    logic [LEN_W-1:0]          len;
    logic [LEN_W-1:0]          off;
    logic [SP_W-1:0]           base;
    logic signed [PWR_W:0]     dp;
    logic signed [16:0]        p;
    logic [PCAP_W+LEN_W-1:0]   capl;
    logic [SP_W-1:0]           pl;
    len  = sec_len(s);
    off  = LEN_W'(soc - curve_soc(s));
    base = SP_W'(curve_pwr(s) * len);
    dp   = $signed({1'b0, curve_pwr(s + 3'd1)}) - $signed({1'b0, curve_pwr(s)});
    p    = $signed({3'b000, base}) + 17'(dp * $signed({1'b0, off}));
    pl   = p[16] ? '0 : SP_W'(p);
    capl = (PCAP_W + LEN_W)'(cap * len);
    if (cap != '0 && (PCAP_W + LEN_W)'(pl) > capl) begin
      pl = SP_W'(capl);
    end
    return pl;
  endfunction

endpackage

[src/charge_time_predictor.sv]
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | capacity_dkwh, power_cap_dkw, start_soc, target_soc
// out     | output    | out_valid/out_ready | charge_minutes
//
// One transaction at a time. Zero capacity or target not above start: the request
// goes straight to the done state. Otherwise each curve section touched (1 to 6)
// passes through setup, load, 38 bit-serial divider steps and accumulate, in that
// order, before the done state registers the result.
// Reset is synchronous, active low, and clears the controller and output valid.
// A stalled result waits in the output register; the next transaction may be
// accepted meanwhile, but its result waits until the register frees up.
module charge_time_predictor import ctp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CAP_W-1:0]  in_capacity_dkwh,
  input  logic [PCAP_W-1:0] in_power_cap_dkw,
  input  logic [SOC_W-1:0]  in_start_soc,
  input  logic [SOC_W-1:0]  in_target_soc,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MIN_W-1:0]  out_charge_minutes
);

  ctp_state_t         state_r, state_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic [PCAP_W-1:0]  pcap_r, pcap_nxt;
  logic [SOC_W-1:0]   from_r, from_nxt;
  logic [SOC_W-1:0]   to_r, to_nxt;
  logic [SEC_W-1:0]   s_r, s_nxt;
  logic [SEC_W-1:0]   fs_r, fs_nxt;
  logic [SEC_W-1:0]   ts_r, ts_nxt;
  logic [PSUM_W-1:0]  psum_r, psum_nxt;
  logic [DL_W-1:0]    dl_r, dl_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [MIN_W-1:0]   minutes_r, minutes_nxt;

  logic [SOC_W-1:0]   from_sat, to_sat;
  logic [SOC_W-1:0]   s1, s2;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   dsoc;
  logic [DEN_W-1:0]   den;
  logic [NUM_W-1:0]   num;
  logic [TOT_W+5:0]   t60;
  logic [TOT_W+5-FRAC_W:0] mins;
  div_req_t           div_req;
  logic               div_done;
  logic [QUO_W-1:0]   div_q;

  ctp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // Saturate the state of charge inputs to 100
  assign from_sat = (in_start_soc > SOC_MAX) ? SOC_MAX : in_start_soc;
  assign to_sat   = (in_target_soc > SOC_MAX) ? SOC_MAX : in_target_soc;

  // Ends of the covered part of the current section
  assign s1   = (s_r == fs_r) ? from_r : curve_soc(s_r);
  assign s2   = (s_r == ts_r) ? to_r : curve_soc(s_r + 3'd1);
  assign len  = sec_len(s_r);
  assign dsoc = LEN_W'(s2 - s1);

  // Division operands: energy term over 100 * power sum, rounded to nearest
  assign den = DEN_W'(psum_r * 7'd100);
  assign num = {22'(cap_r * dl_r), {FRAC_W{1'b0}}} + NUM_W'(den >> 1);

  // Minutes = ceil(total * 60 / 2^16), saturated
  assign t60  = {total_r, 6'b0} - {4'b0, total_r, 2'b0};
  assign mins = (TOT_W + 5 - FRAC_W + 1)'((t60 + 34'(16'hFFFF)) >> FRAC_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cap_r     <= cap_nxt;
    pcap_r    <= pcap_nxt;
    from_r    <= from_nxt;
    to_r      <= to_nxt;
    s_r       <= s_nxt;
    fs_r      <= fs_nxt;
    ts_r      <= ts_nxt;
    psum_r    <= psum_nxt;
    dl_r      <= dl_nxt;
    total_r   <= total_nxt;
    minutes_r <= minutes_nxt;
  end

  // Next state and datapath control
  always_comb begin
    state_nxt        = state_r;
    cap_nxt          = cap_r;
    pcap_nxt         = pcap_r;
    from_nxt         = from_r;
    to_nxt           = to_r;
    s_nxt            = s_r;
    fs_nxt           = fs_r;
    ts_nxt           = ts_r;
    psum_nxt         = psum_r;
    dl_nxt           = dl_r;
    total_nxt        = total_r;
    minutes_nxt      = minutes_r;
    out_valid_nxt    = out_valid_r & ~out_ready;
    div_req.start    = 1'b0;
    div_req.dividend = num;
    div_req.divisor  = den;
    in_ready         = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cap_nxt   = in_capacity_dkwh;
          pcap_nxt  = in_power_cap_dkw;
          from_nxt  = from_sat;
          to_nxt    = to_sat;
          fs_nxt    = section_of(from_sat);
          ts_nxt    = section_of(to_sat);
          s_nxt     = section_of(from_sat);
          total_nxt = '0;
          if (in_capacity_dkwh == '0 || to_sat <= from_sat) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        // Interpolated, capped powers at both ends of the part
        psum_nxt  = PSUM_W'(scaled_power(s_r, s1, pcap_r))
                  + PSUM_W'(scaled_power(s_r, s2, pcap_r));
        dl_nxt    = DL_W'({(DL_W-1)'(dsoc * len), 1'b0});
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          total_nxt = total_r + TOT_W'(div_q);
          if (s_r == ts_r) begin
            state_nxt = ST_DONE;
          end else begin
            s_nxt     = s_r + 3'd1;
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          minutes_nxt   = (mins > (TOT_W + 5 - FRAC_W + 1)'(MIN_SAT)) ? MIN_SAT
                                                                      : MIN_W'(mins);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_charge_minutes = minutes_r;

`ifndef SYNTHESIS
  a_zero_cap_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_capacity_dkwh == '0) |=> (state_r == ST_DONE))
    else $error("zero capacity did not skip the sections");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_section_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SETUP) |-> (s_r >= fs_r && s_r <= ts_r))
    else $error("section index out of the covered range");

  a_result_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (state_r == ST_IDLE))
    else $error("result shown while work still in progress");
`endif

endmodule

[src/ctp_div.sv]
module ctp_div import ctp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [NUM_W-1:0] nq_r, nq_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   shifted;
  logic             ge;

  // One restoring step a cycle: dividend bits leave the top, quotient bits enter below
  always_comb begin
    shifted  = {rem_r, nq_r[NUM_W-1]};
    ge       = shifted >= {1'b0, den_r};
    cnt_nxt  = cnt_r;
    nq_nxt   = nq_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    if (req.start) begin
      cnt_nxt = DIV_STEPS;
      nq_nxt  = req.dividend;
      rem_nxt = '0;
      den_nxt = req.divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      nq_nxt   = {nq_r[NUM_W-2:0], ge};
      rem_nxt  = ge ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nq_r  <= nq_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = nq_r[QUO_W-1:0];

endmodule

[sim/ctp_minutes_check.sv]
`timescale 1ns / 100ps

module ctp_minutes_check import ctp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CAP_W-1:0]  in_capacity_dkwh,
  input  logic [PCAP_W-1:0] in_power_cap_dkw,
  input  logic [SOC_W-1:0]  in_start_soc,
  input  logic [SOC_W-1:0]  in_target_soc,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [MIN_W-1:0]  out_charge_minutes,
  output int                mismatches,
  output int                pending,
  output int                results_seen
);

  // One outstanding request and the minute count it must produce
  typedef struct packed {
    logic [CAP_W-1:0]  capacity;
    logic [PCAP_W-1:0] power_cap;
    logic [SOC_W-1:0]  soc_from;
    logic [SOC_W-1:0]  soc_to;
    logic [MIN_W-1:0]  minutes;
  } minutes_due_t;

  minutes_due_t minutes_due[$];
  minutes_due_t oldest;
  minutes_due_t fresh;

  // Curve corner points: state of charge in percent, power in 0.1 kW
  function automatic int point_soc(input int i);
    case (i)
      0:       return 0;
      1:       return 30;
      2:       return 55;
      3:       return 76;
      4:       return 81;
      5:       return 91;
      default: return 100;
    endcase
  endfunction

  function automatic int point_pwr(input int i);
    case (i)
      0:       return 300;
      1:       return 325;
      2:       return 265;
      3:       return 185;
      4:       return 110;
      5:       return 65;
      default: return 30;
    endcase
  endfunction

  // Section whose upper end is the first curve point at or above soc
  function automatic int curve_section(input int soc);
    for (int i = 0; i < 6; i++) begin
      if (soc <= point_soc(i + 1)) return i;
    end
    return 5;
  endfunction

  // Interpolated power times section length, floored at zero and limited by the cap
  function automatic longint capped_power(input int s, input int soc, input longint cap);
    longint len;
    longint off;
    longint p;
    len = point_soc(s + 1) - point_soc(s);
    off = soc - point_soc(s);
    p   = point_pwr(s) * len + off * (point_pwr(s + 1) - point_pwr(s));
    if (p < 0) p = 0;
    if (cap > 0 && p > cap * len) p = cap * len;
    return p;
  endfunction

  // Sum the per-section hours in Q16, then round up to whole minutes
  function automatic logic [MIN_W-1:0] predict_minutes(input logic [CAP_W-1:0]  capacity,
                                                       input logic [PCAP_W-1:0] power_cap,
                                                       input logic [SOC_W-1:0]  soc_from,
                                                       input logic [SOC_W-1:0]  soc_to);
    int     lo;
    int     hi;
    int     first_sec;
    int     last_sec;
    int     part_lo;
    int     part_hi;
    longint len;
    longint den;
    longint num;
    longint hours_q16;
    longint minutes;
    lo = (soc_from > SOC_MAX) ? int'(SOC_MAX) : int'(soc_from);
    hi = (soc_to > SOC_MAX) ? int'(SOC_MAX) : int'(soc_to);
    if (capacity == '0 || hi <= lo) return '0;
    first_sec = curve_section(lo);
    last_sec  = curve_section(hi);
    hours_q16 = 0;
    for (int s = first_sec; s <= last_sec; s++) begin
      part_lo = (s == first_sec) ? lo : point_soc(s);
      part_hi = (s == last_sec) ? hi : point_soc(s + 1);
      len = point_soc(s + 1) - point_soc(s);
      den = 100 * (capped_power(s, part_lo, longint'(power_cap)) +
                   capped_power(s, part_hi, longint'(power_cap)));
      num = longint'(capacity) * (part_hi - part_lo) * 2 * len * 65536;
      if (den != 0) hours_q16 += (num + den / 2) / den;
    end
    minutes = (hours_q16 * 60 + 65535) >> FRAC_W;
    if (minutes > 65535) minutes = 65535;
    return MIN_W'(minutes);
  endfunction

  // Check the result first, then queue the new request, so a same-cycle pair stays in order
  always @(posedge clk) begin
    if (!rst_n) begin
      minutes_due.delete();
      mismatches   <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (minutes_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result %0d minutes with no request outstanding",
                     $realtime, out_charge_minutes);
          mismatches <= mismatches + 1;
        end else begin
          oldest = minutes_due.pop_front();
          if (out_charge_minutes !== oldest.minutes) begin
            if (mismatches < 10)
              $display("%0t: cap %0d dkWh, limit %0d dkW, soc %0d->%0d: expected %0d, got %0d",
                       $realtime, oldest.capacity, oldest.power_cap, oldest.soc_from,
                       oldest.soc_to, oldest.minutes, out_charge_minutes);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh.capacity  = in_capacity_dkwh;
        fresh.power_cap = in_power_cap_dkw;
        fresh.soc_from  = in_start_soc;
        fresh.soc_to    = in_target_soc;
        fresh.minutes   = predict_minutes(in_capacity_dkwh, in_power_cap_dkw,
                                          in_start_soc, in_target_soc);
        minutes_due.push_back(fresh);
      end
    end
    pending <= minutes_due.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb import ctp_pkg::*;;

  localparam int RANDOM_REQUESTS = 1100;
  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int DRAIN_CYCLES    = 300;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CAP_W-1:0]  in_capacity_dkwh = '0;
  logic [PCAP_W-1:0] in_power_cap_dkw = '0;
  logic [SOC_W-1:0]  in_start_soc = '0;
  logic [SOC_W-1:0]  in_target_soc = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MIN_W-1:0]  out_charge_minutes;

  int mismatches;
  int pending;
  int results_seen;
  int requests_sent = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  always #5 clk = ~clk;

  charge_time_predictor uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_capacity_dkwh   (in_capacity_dkwh),
    .in_power_cap_dkw   (in_power_cap_dkw),
    .in_start_soc       (in_start_soc),
    .in_target_soc      (in_target_soc),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_charge_minutes (out_charge_minutes)
  );

  ctp_minutes_check minutes_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_capacity_dkwh   (in_capacity_dkwh),
    .in_power_cap_dkw   (in_power_cap_dkw),
    .in_start_soc       (in_start_soc),
    .in_target_soc      (in_target_soc),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_charge_minutes (out_charge_minutes),
    .mismatches         (mismatches),
    .pending            (pending),
    .results_seen       (results_seen)
  );

  // Idle cycles before the next transaction on either side
  function automatic int pick_gap();
    return no_idle ? 0 : int'($urandom_range(0, 10));
  endfunction

  // Present one request and hold it until the block takes it
  task automatic send_request(input logic [CAP_W-1:0]  capacity,
                              input logic [PCAP_W-1:0] power_cap,
                              input logic [SOC_W-1:0]  soc_from,
                              input logic [SOC_W-1:0]  soc_to);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_capacity_dkwh <= capacity;
    in_power_cap_dkw <= power_cap;
    in_start_soc     <= soc_from;
    in_target_soc    <= soc_to;
    do @(posedge clk); while (in_ready !== 1'b1);
    requests_sent++;
  endtask

  // Mostly well-formed charge windows, with zero capacity, reversed and out-of-range socs mixed in
  task automatic send_random_request();
    logic [CAP_W-1:0]  capacity;
    logic [PCAP_W-1:0] power_cap;
    int                soc_from;
    int                soc_to;
    case ($urandom_range(0, 19))
      0:       capacity = '0;
      1:       capacity = CAP_W'($urandom_range(0, 2047));
      2:       capacity = CAP_W'($urandom_range(1, 20));
      default: capacity = CAP_W'($urandom_range(1, 2000));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: power_cap = '0;
      3:       power_cap = PCAP_W'($urandom_range(0, 4095));
      4:       power_cap = PCAP_W'($urandom_range(1, 50));
      default: power_cap = PCAP_W'($urandom_range(20, 400));
    endcase
    case ($urandom_range(0, 9))
      0: begin
        soc_from = $urandom_range(0, 127);
        soc_to   = $urandom_range(0, 127);
      end
      1: begin
        case ($urandom_range(0, 5))
          0:       soc_from = 0;
          1:       soc_from = 30;
          2:       soc_from = 55;
          3:       soc_from = 76;
          4:       soc_from = 81;
          default: soc_from = 91;
        endcase
        soc_to = $urandom_range(soc_from + 1, 100);
      end
      2: begin
        soc_from = $urandom_range(0, 110);
        soc_to   = $urandom_range(100, 127);
      end
      default: begin
        soc_from = $urandom_range(0, 99);
        soc_to   = $urandom_range(soc_from + 1, 100);
      end
    endcase
    send_request(capacity, power_cap, SOC_W'(soc_from), SOC_W'(soc_to));
  endtask

  // Accept results after a random stall each
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("[charge_time_predictor] ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Zero-time cases: empty battery, target at or below start, both socs saturating
    send_request(11'd0, 12'd0, 7'd0, 7'd100);
    send_request(11'd600, 12'd0, 7'd50, 7'd50);
    send_request(11'd600, 12'd0, 7'd80, 7'd20);
    send_request(11'd600, 12'd0, 7'd127, 7'd127);
    send_request(11'd600, 12'd0, 7'd100, 7'd100);
    send_request(11'd600, 12'd0, 7'd0, 7'd0);
    // Full and single-percent windows at the field extremes
    send_request(11'd2000, 12'd0, 7'd0, 7'd100);
    send_request(11'd2047, 12'd4095, 7'd0, 7'd100);
    send_request(11'd2000, 12'd1, 7'd0, 7'd100);
    send_request(11'd2047, 12'd1, 7'd0, 7'd127);
    send_request(11'd1, 12'd3000, 7'd0, 7'd1);
    send_request(11'd1, 12'd0, 7'd99, 7'd100);
    // Target above 100 saturates, start taken as is
    send_request(11'd500, 12'd0, 7'd99, 7'd127);
    // Starts and targets exactly on curve points, one window per pair of neighbouring points from 30 up
    send_request(11'd400, 12'd0, 7'd30, 7'd55);
    send_request(11'd400, 12'd0, 7'd55, 7'd76);
    send_request(11'd400, 12'd0, 7'd76, 7'd81);
    send_request(11'd400, 12'd0, 7'd81, 7'd91);
    send_request(11'd400, 12'd0, 7'd91, 7'd100);
    // Power limits, one that clamps only part of the curve and two above all of it
    send_request(11'd777, 12'd150, 7'd20, 7'd95);
    send_request(11'd1365, 12'd2730, 7'd1, 7'd99);
    send_request(11'd682, 12'd1365, 7'd64, 7'd90);

    // Random part, switching between idling and back-to-back phases
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_random_request();
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d charge-time requests (21 directed, rest random), %0d results compared",
             requests_sent, results_seen);
    $display("Covered zero-time, power-limited, saturating and soc-out-of-range requests");
    if (mismatches == 0 && pending == 0) begin
      $display("[charge_time_predictor] OK");
    end else begin
      $display("[charge_time_predictor] ERROR");
    end
    $finish;
  end

endmodule
